@@ design/pmtc_pkg.sv @@
// pmtc_pkg: shared constants for the per-mac traffic counter table
// operation codes, table sizing and beat widths
// no dependencies
package pmtc_pkg;

	localparam int TABLE_ENTRIES = 16;
	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

	localparam int MAC_W = 48;
	localparam int TAG_W = 32;
	localparam int CTR_W = 32;
	localparam int LEN_W = 16;
	localparam int OP_W = 3;

	localparam int S_DATA_W = 224;
	localparam int M_DATA_W = 192;

	// group bit sits at the bottom of the first octet
	localparam int GROUP_BIT_POS = 40;

	typedef enum logic [OP_W-1:0] {
		OP_PACKET = 3'd0,
		OP_TICK = 3'd1,
		OP_UPD_BEGIN = 3'd2,
		OP_UPD_ITEM = 3'd3,
		OP_UPD_END = 3'd4
	} op_t;

endpackage

@@ design/per_mac_traffic_counter_table.sv @@
// per_mac_traffic_counter_table: endpoint table with per-mac tx/rx counters
// tags, macs and ages in flip-flops, counters in one synchronous memory
// depends on pmtc_pkg
//
// Takes one item at a time. A packet does two read-modify-writes of the
// counter memory, source then destination, each a read state and then a
// write state. An update end checks all TABLE_ENTRIES entries, one entry
// checked per cycle. A tick gives one beat per valid entry (none on an
// empty table), newest entry first; each entry is read from the counter
// memory's single read port, then its beat waits in the output register
// until taken. No clearing pass is needed after reset.
module per_mac_traffic_counter_table (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	// frame_length, dest_mac, src_mac, endpoint_tag, endpoint_mac, time_ms
	input logic [pmtc_pkg::S_DATA_W-1:0] s_tdata,
	// operation
	input logic [pmtc_pkg::OP_W-1:0] s_tuser,
	output logic m_tvalid,
	input logic m_tready,
	// report_tag, report_time, tx_packets, tx_bytes, rx_packets, rx_bytes
	output logic [pmtc_pkg::M_DATA_W-1:0] m_tdata,
	output logic m_tlast
);

	localparam int N = pmtc_pkg::TABLE_ENTRIES;
	localparam int IW = pmtc_pkg::IDX_W;
	localparam int CW = pmtc_pkg::CNT_W;
	localparam int WORD_W = 4 * pmtc_pkg::CTR_W;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DONE,
		ST_P_LOOK,
		ST_P_WSRC,
		ST_P_RDST,
		ST_P_WDST,
		ST_T_RD,
		ST_T_LD,
		ST_U_BEGIN,
		ST_U_ITEM,
		ST_U_SWEEP
	} state_t;

	state_t state_q;

	// captured item
	logic [pmtc_pkg::LEN_W-1:0] len_q;
	logic [pmtc_pkg::MAC_W-1:0] dmac_q, smac_q, emac_q;
	logic [pmtc_pkg::TAG_W-1:0] tag_q;
	logic [pmtc_pkg::CTR_W-1:0] time_q;

	// table in flip-flops
	logic [N-1:0] valid_q, stale_q;
	logic [pmtc_pkg::TAG_W-1:0] ent_tag_q [N];
	logic [pmtc_pkg::MAC_W-1:0] ent_mac_q [N];
	logic [IW-1:0] ent_age_q [N];
	logic [CW-1:0] count_q;

	// walk registers
	logic [IW-1:0] idx_q, rank_q, key_q;
	logic dst_hit_q;
	logic [IW-1:0] dst_idx_q;

	// counter memory, word = {rx_bytes, rx_packets, tx_bytes, tx_packets}
	logic [WORD_W-1:0] cnt_mem [N];
	logic [WORD_W-1:0] rd_data_q;
	logic rd_en, wr_en;
	logic [IW-1:0] rd_addr, wr_addr;
	logic [WORD_W-1:0] wr_data;

	logic m_tvalid_q, m_tlast_q;
	logic [pmtc_pkg::M_DATA_W-1:0] m_tdata_q;
	logic beat_load;

	// one-hot of the newest among the hits: no other hit is younger
	function automatic logic [N-1:0] newest(input logic [N-1:0] hit);
		logic [N-1:0] res;
		res = '0;
		for (int i = 0; i < N; i++) begin
			res[i] = hit[i];
			for (int j = 0; j < N; j++) begin
				if (j != i && hit[j] && ent_age_q[j] < ent_age_q[i])
					res[i] = 1'b0;
			end
		end
		return res;
	endfunction

	function automatic logic [IW-1:0] encode(input logic [N-1:0] oh);
		logic [IW-1:0] res;
		res = '0;
		for (int i = 0; i < N; i++) begin
			if (oh[i])
				res = res | IW'(i);
		end
		return res;
	endfunction

	logic [N-1:0] src_hit_v, dst_hit_v, tag_hit_v, rank_hit_v, src_oh, dst_oh, tag_oh;
	logic [N-1:0] free_oh;
	logic [IW-1:0] src_idx, dst_idx, tag_idx, rank_idx, free_idx;
	logic dst_unicast;
	logic tick_last;

	always_comb begin
		for (int i = 0; i < N; i++) begin
			src_hit_v[i] = valid_q[i] && ent_mac_q[i] == smac_q;
			dst_hit_v[i] = valid_q[i] && ent_mac_q[i] == dmac_q;
			tag_hit_v[i] = valid_q[i] && ent_tag_q[i] == tag_q;
			rank_hit_v[i] = valid_q[i] && ent_age_q[i] == rank_q;
		end
		// first free slot
		free_oh = '0;
		for (int i = N - 1; i >= 0; i--) begin
			if (!valid_q[i])
				free_oh = N'(1) << i;
		end
	end

	// ages are read inside newest, so keep this procedural
	always_comb begin
		src_oh = newest(src_hit_v);
		dst_oh = newest(dst_hit_v);
		tag_oh = newest(tag_hit_v);
	end

	assign dst_unicast = !dmac_q[pmtc_pkg::GROUP_BIT_POS];
	assign src_idx = encode(src_oh);
	assign dst_idx = encode(dst_oh);
	assign tag_idx = encode(tag_oh);
	assign rank_idx = encode(rank_hit_v);
	assign free_idx = encode(free_oh);
	assign tick_last = {1'b0, rank_q} == CW'(count_q - CW'(1));
	assign beat_load = state_q == ST_T_LD && (!m_tvalid_q || m_tready);

	// memory port control
	always_comb begin
		rd_en = 1'b0;
		rd_addr = src_idx;
		wr_en = 1'b0;
		wr_addr = key_q;
		wr_data = '0;
		unique case (state_q)
			ST_P_LOOK: begin
				rd_en = 1'b1;
				rd_addr = src_idx;
			end
			ST_P_WSRC: begin
				wr_en = |src_oh;
				wr_addr = key_q;
				wr_data = rd_data_q;
				wr_data[31:0] = rd_data_q[31:0] + 32'd1;
				wr_data[63:32] = rd_data_q[63:32] + {16'd0, len_q};
			end
			ST_P_RDST: begin
				rd_en = 1'b1;
				rd_addr = dst_idx_q;
			end
			ST_P_WDST: begin
				wr_en = dst_hit_q;
				wr_addr = dst_idx_q;
				wr_data = rd_data_q;
				wr_data[95:64] = rd_data_q[95:64] + 32'd1;
				wr_data[127:96] = rd_data_q[127:96] + {16'd0, len_q};
			end
			ST_T_RD: begin
				rd_en = 1'b1;
				rd_addr = rank_idx;
			end
			ST_T_LD: begin
				wr_en = beat_load;
				wr_addr = key_q;
			end
			ST_U_ITEM: begin
				wr_en = !(|tag_oh) && count_q < CW'(N);
				wr_addr = free_idx;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			cnt_mem[wr_addr] <= wr_data;
		if (rd_en)
			rd_data_q <= cnt_mem[rd_addr];
	end

	// payload of the table, no reset needed
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_tvalid) begin
			len_q <= s_tdata[15:0];
			dmac_q <= s_tdata[63:16];
			smac_q <= s_tdata[111:64];
			tag_q <= s_tdata[143:112];
			emac_q <= s_tdata[191:144];
			time_q <= s_tdata[223:192];
		end
		if (state_q == ST_P_LOOK)
			dst_idx_q <= dst_idx;
		if (state_q == ST_U_ITEM && !(|tag_oh) && count_q < CW'(N)) begin
			ent_tag_q[free_idx] <= tag_q;
			ent_mac_q[free_idx] <= emac_q;
		end
		if (beat_load) begin
			m_tdata_q <= {rd_data_q[127:96], rd_data_q[95:64], rd_data_q[63:32],
				rd_data_q[31:0], time_q, ent_tag_q[key_q]};
			m_tlast_q <= tick_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			valid_q <= '0;
			stale_q <= '0;
			count_q <= '0;
			idx_q <= '0;
			rank_q <= '0;
			key_q <= '0;
			dst_hit_q <= 1'b0;
			m_tvalid_q <= 1'b0;
			for (int i = 0; i < N; i++)
				ent_age_q[i] <= '0;
		end else begin
			if (beat_load)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						idx_q <= '0;
						rank_q <= '0;
						unique case (s_tuser)
							pmtc_pkg::OP_PACKET: state_q <= ST_P_LOOK;
							pmtc_pkg::OP_TICK:
								state_q <= (count_q != '0) ? ST_T_RD : ST_DONE;
							pmtc_pkg::OP_UPD_BEGIN: state_q <= ST_U_BEGIN;
							pmtc_pkg::OP_UPD_ITEM: state_q <= ST_U_ITEM;
							pmtc_pkg::OP_UPD_END: state_q <= ST_U_SWEEP;
							default: state_q <= ST_DONE;
						endcase
					end
				end
				ST_DONE: state_q <= ST_IDLE;
				ST_P_LOOK: begin
					key_q <= src_idx;
					dst_hit_q <= dst_unicast && |dst_oh;
					state_q <= ST_P_WSRC;
				end
				// source written back before the destination is read
				ST_P_WSRC: state_q <= ST_P_RDST;
				ST_P_RDST: state_q <= ST_P_WDST;
				ST_P_WDST: state_q <= ST_IDLE;
				ST_T_RD: begin
					key_q <= rank_idx;
					state_q <= ST_T_LD;
				end
				ST_T_LD: begin
					if (beat_load) begin
						rank_q <= rank_q + IW'(1);
						state_q <= tick_last ? ST_IDLE : ST_T_RD;
					end
				end
				ST_U_BEGIN: begin
					stale_q <= valid_q;
					state_q <= ST_IDLE;
				end
				ST_U_ITEM: begin
					if (|tag_oh) begin
						stale_q[tag_idx] <= 1'b0;
					end else if (count_q < CW'(N)) begin
						for (int i = 0; i < N; i++) begin
							if (valid_q[i])
								ent_age_q[i] <= ent_age_q[i] + IW'(1);
						end
						ent_age_q[free_idx] <= '0;
						valid_q[free_idx] <= 1'b1;
						stale_q[free_idx] <= 1'b0;
						count_q <= count_q + CW'(1);
					end
					state_q <= ST_IDLE;
				end
				ST_U_SWEEP: begin
					if (valid_q[idx_q] && stale_q[idx_q]) begin
						valid_q[idx_q] <= 1'b0;
						stale_q[idx_q] <= 1'b0;
						count_q <= count_q - CW'(1);
						for (int i = 0; i < N; i++) begin
							if (valid_q[i] && ent_age_q[i] > ent_age_q[idx_q])
								ent_age_q[i] <= ent_age_q[i] - IW'(1);
						end
					end
					idx_q <= idx_q + IW'(1);
					if (idx_q == IW'(N - 1))
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign s_tready = state_q == ST_IDLE;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;
	assign m_tlast = m_tlast_q;

endmodule

@@ design/pmtc_checker.sv @@
// pmtc_checker: port-level checks for the per-mac traffic counter table
// bound onto per_mac_traffic_counter_table, depends on pmtc_pkg
module pmtc_checker (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	input logic s_tready,
	input logic [pmtc_pkg::OP_W-1:0] s_tuser,
	input logic m_tvalid,
	input logic m_tready,
	input logic [pmtc_pkg::M_DATA_W-1:0] m_tdata,
	input logic m_tlast
);

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("result beat changed while stalled");

	// the block is never ready straight after accepting an item
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("ready straight after an accepted beat");

	// only a tick produces result beats
	a_no_result_non_tick: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser != pmtc_pkg::OP_TICK |=> !$rose(m_tvalid))
		else $error("result beat from a non-tick item");

	// no new beat appears while the block is idle
	a_idle_no_new_beat: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready && !m_tvalid |=> !m_tvalid)
		else $error("result beat appeared while idle");

endmodule

bind per_mac_traffic_counter_table pmtc_checker u_pmtc_checker (
	.clk(clk),
	.arst_n(arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.s_tuser(s_tuser),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata(m_tdata),
	.m_tlast(m_tlast)
);
